// ----- rtl/core/hcb_pkg.sv -----
package hcb_pkg;
  localparam int ALPHABET_DEF = 26;
  localparam int COUNT_BITS_DEF = 24;
  localparam int MAX_CODE_LEN_DEF = 25;
  localparam int SYM_W = 5;
  localparam int CODE_W = 25;
  localparam int LEN_W = 5;
endpackage

// ----- rtl/core/hcb_if.sv -----
interface hcb_in_if #(parameter int COUNT_BITS = hcb_pkg::COUNT_BITS_DEF);
  logic valid;
  logic ready;
  logic [hcb_pkg::SYM_W-1:0] symbol;
  logic [COUNT_BITS-1:0] count;
  logic last;
  modport source (output valid, symbol, count, last, input ready);
  modport sink (input valid, symbol, count, last, output ready);
endinterface

interface hcb_out_if;
  logic valid;
  logic ready;
  logic [hcb_pkg::SYM_W-1:0] code_symbol;
  logic [hcb_pkg::CODE_W-1:0] code_bits;
  logic [hcb_pkg::LEN_W-1:0] code_length;
  logic empty_res;
  logic final_res;
  modport source (output valid, code_symbol, code_bits, code_length, empty_res, final_res,
                  input ready);
  modport sink (input valid, code_symbol, code_bits, code_length, empty_res, final_res,
                output ready);
endinterface

// ----- rtl/core/huffman_code_builder_core.sv -----
// Huffman code builder. Letter words (symbol, count, last) are taken one per
// cycle. Zero counts are dropped, and up to ALPHABET letters are kept in
// arrival order. After the word with last set, the core builds a binary
// min-heap over the leaves, merges the two smallest nodes until one root is
// left, and then walks each leaf up to the root to form its code. One code
// word per letter comes out in arrival order, with the first branch in the
// most significant used bit. A lone letter has length 0, and an empty set
// gives one word with empty_res set. Input is not ready from the word with
// last set until the final code word has been taken.
//
// After loading, all work runs through node memories with registered reads,
// one step a cycle. Each heap level of a sift-down reads the node, compares
// it with the left child and then the right child, and swaps (read, left
// compare, right compare, swap); the sift-down stops at the level where no
// child is smaller. The heap build sifts down each start node, last parent
// first. Each merge decides, pops two nodes with a sift-down each, joins the
// pair, and sifts the new node up before placing it. Each code word walks its
// leaf up to the root, one code bit per parent link, and waits while the
// output is stalled. The time after the last word is set mostly by the heap
// depth and the code lengths.
module huffman_code_builder_core #(
  parameter int ALPHABET = hcb_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
  input logic clk,
  input logic rst,
  hcb_in_if.sink in_ch,
  hcb_out_if.source out_ch
);
  localparam int NODES = 2 * ALPHABET - 1;
  localparam int NW = $clog2(NODES + 1);
  localparam int HW = $clog2(ALPHABET + 1);
  localparam int LW = $clog2(ALPHABET);
  localparam int WW = COUNT_BITS + $clog2(ALPHABET) + 1;
  localparam int CLW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW = hcb_pkg::CODE_W;
  localparam int LNW = hcb_pkg::LEN_W;

  typedef enum logic [4:0] {
    S_LOAD, S_HEAPIFY, S_SD_C, S_SD_L, S_SD_LC, S_SD_RC, S_SD_SW,
    S_MERGE, S_TAKE, S_SUM, S_SUM_A, S_SUM_B, S_SUM_W, S_UP, S_UP_CMP,
    S_WALK, S_WALK_CHK, S_WALK_RD, S_OUT
  } state_t;

  state_t state;

  // Letter table and heap are small register arrays; node weights and
  // parent links live in memories read one address a cycle.
  logic [hcb_pkg::SYM_W-1:0] sym_mem [ALPHABET];
  logic [NW-1:0] heap [ALPHABET];
  logic [WW-1:0] wt [NODES];
  logic [NW:0] pmem [NODES];

  logic [WW-1:0] wt_q;
  logic [NW:0] pm_q;
  logic wt_we, pm_we;
  logic [NW-1:0] wt_wa, wt_ra, pm_wa;
  logic [WW-1:0] wt_wd;
  logic [NW:0] pm_wd;

  logic [HW-1:0] loaded, n_set, hcnt, n_next;
  logic [NW-1:0] next_node, node_a, node_b, cur_node, root;
  logic [HW-1:0] cur, best, hi, k, pidx;
  logic [HW:0] lchild, rchild;
  logic [WW-1:0] best_w, sum_w;
  logic take_second, sd_merge, take_in;
  logic [CW-1:0] bits;
  logic [CLW-1:0] len;
  logic [NW:0] guard;

  assign lchild = {cur, 1'b1};
  assign rchild = {cur, 1'b0} + (HW+1)'(2);
  assign pidx = (cur - HW'(1)) >> 1;

  // A word with a nonzero count is kept while there is room.
  assign take_in = (in_ch.count != '0) && (loaded < HW'(ALPHABET));
  assign n_next = take_in ? loaded + HW'(1) : loaded;

  // A pending code word holds off loading so that an empty set cannot
  // overwrite it.
  assign in_ch.ready = (state == S_LOAD) && !out_ch.valid;

  always_comb begin
    wt_we = 1'b0;
    wt_wa = NW'(loaded);
    wt_wd = WW'(in_ch.count);
    wt_ra = '0;
    pm_we = 1'b0;
    pm_wa = node_a;
    pm_wd = {1'b0, next_node};
    unique case (state)
      S_LOAD: wt_we = in_ch.valid && in_ch.ready && take_in;
      S_SD_C: wt_ra = heap[LW'(cur)];
      S_SD_L: wt_ra = heap[LW'(lchild)];
      S_SD_LC: wt_ra = heap[LW'(rchild)];
      S_SUM: wt_ra = node_a;
      S_SUM_A: begin
        wt_ra = node_b;
        pm_we = 1'b1;
      end
      S_SUM_B: begin
        pm_we = 1'b1;
        pm_wa = node_b;
        pm_wd = {1'b1, next_node};
      end
      S_SUM_W: begin
        wt_we = 1'b1;
        wt_wa = next_node;
        wt_wd = sum_w;
      end
      S_UP: wt_ra = heap[LW'(pidx)];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt[wt_wa] <= wt_wd;
    wt_q <= wt[wt_ra];
    if (pm_we) pmem[pm_wa] <= pm_wd;
    pm_q <= pmem[cur_node];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      loaded <= '0;
      hcnt <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_ch.valid && in_ch.ready) begin
            loaded <= in_ch.last ? '0 : n_next;
            if (take_in) begin
              sym_mem[LW'(loaded)] <= in_ch.symbol;
              heap[LW'(loaded)] <= NW'(loaded);
            end
            if (in_ch.last) begin
              n_set <= n_next;
              hcnt <= n_next;
              next_node <= NW'(n_next);
              hi <= (n_next >= HW'(2)) ? ((n_next - HW'(2)) >> 1) + HW'(1) : '0;
              sd_merge <= 1'b0;
              if (n_next == '0) begin
                // Empty set: a single flagged word, then back to loading.
                out_ch.code_symbol <= '0;
                out_ch.code_bits <= '0;
                out_ch.code_length <= '0;
                out_ch.empty_res <= 1'b1;
                out_ch.final_res <= 1'b1;
                out_ch.valid <= 1'b1;
              end else begin
                state <= S_HEAPIFY;
              end
            end
          end
        end
        S_HEAPIFY: begin
          // Bottom-up build, last parent first.
          if (hi == '0) begin
            sd_merge <= 1'b1;
            state <= S_MERGE;
          end else begin
            hi <= hi - HW'(1);
            cur <= hi - HW'(1);
            state <= S_SD_C;
          end
        end
        S_SD_C: state <= S_SD_L;
        S_SD_L: begin
          best <= cur;
          best_w <= wt_q;
          state <= (lchild < {1'b0, hcnt}) ? S_SD_LC : S_SD_SW;
        end
        S_SD_LC: begin
          if (wt_q < best_w) begin
            best <= HW'(lchild);
            best_w <= wt_q;
          end
          state <= (rchild < {1'b0, hcnt}) ? S_SD_RC : S_SD_SW;
        end
        S_SD_RC: begin
          if (wt_q < best_w) best <= HW'(rchild);
          state <= S_SD_SW;
        end
        S_SD_SW: begin
          if (best == cur) begin
            if (!sd_merge) begin
              state <= S_HEAPIFY;
            end else if (!take_second) begin
              take_second <= 1'b1;
              state <= S_TAKE;
            end else begin
              state <= S_SUM;
            end
          end else begin
            heap[LW'(best)] <= heap[LW'(cur)];
            heap[LW'(cur)] <= heap[LW'(best)];
            cur <= best;
            state <= S_SD_C;
          end
        end
        S_MERGE: begin
          if (hcnt > HW'(1) && next_node < NW'(NODES)) begin
            take_second <= 1'b0;
            state <= S_TAKE;
          end else begin
            root <= heap[0];
            k <= '0;
            state <= S_WALK;
          end
        end
        S_TAKE: begin
          // Pop the top, move the tail to the top and sift it down.
          if (take_second) node_b <= heap[0];
          else node_a <= heap[0];
          heap[0] <= heap[LW'(hcnt - HW'(1))];
          hcnt <= hcnt - HW'(1);
          cur <= '0;
          state <= S_SD_C;
        end
        S_SUM: state <= S_SUM_A;
        S_SUM_A: begin
          sum_w <= wt_q;
          state <= S_SUM_B;
        end
        S_SUM_B: begin
          sum_w <= sum_w + wt_q;
          state <= S_SUM_W;
        end
        S_SUM_W: begin
          cur <= hcnt;
          hcnt <= hcnt + HW'(1);
          state <= S_UP;
        end
        S_UP: begin
          if (cur == '0) begin
            heap[0] <= next_node;
            next_node <= next_node + NW'(1);
            state <= S_MERGE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (sum_w < wt_q) begin
            heap[LW'(cur)] <= heap[LW'(pidx)];
            cur <= pidx;
            state <= S_UP;
          end else begin
            heap[LW'(cur)] <= next_node;
            next_node <= next_node + NW'(1);
            state <= S_MERGE;
          end
        end
        S_WALK: begin
          cur_node <= NW'(k);
          bits <= '0;
          len <= '0;
          guard <= '0;
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (cur_node != root && guard < (NW+1)'(NODES)) state <= S_WALK_RD;
          else state <= S_OUT;
        end
        S_WALK_RD: begin
          // The leaf-side branch lands in bit 0; the length saturates.
          if (len < CLW'(MAX_CODE_LEN)) begin
            bits <= bits | (CW'(pm_q[NW]) << len);
            len <= len + CLW'(1);
          end
          cur_node <= pm_q[NW-1:0];
          guard <= guard + (NW+1)'(1);
          state <= S_WALK_CHK;
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.code_symbol <= sym_mem[LW'(k)];
            out_ch.code_bits <= bits;
            out_ch.code_length <= LNW'(len);
            out_ch.empty_res <= 1'b0;
            out_ch.final_res <= (k + HW'(1) == n_set);
            out_ch.valid <= 1'b1;
            k <= k + HW'(1);
            state <= (k + HW'(1) == n_set) ? S_LOAD : S_WALK;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- sim/tb_huffman_code_builder_core.sv -----
`timescale 1ns / 1ps

module tb_huffman_code_builder_core;
  localparam int NLET = hcb_pkg::ALPHABET_DEF;
  localparam int NNODE = 2 * NLET - 1;
  localparam int CBITS = hcb_pkg::COUNT_BITS_DEF;
  localparam int SW = hcb_pkg::SYM_W;
  localparam int CW = hcb_pkg::CODE_W;
  localparam int LNW = hcb_pkg::LEN_W;
  localparam int MAXLEN = hcb_pkg::MAX_CODE_LEN_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [SW-1:0] symbol;
    logic [CBITS-1:0] count;
    logic last;
  } letter_t;

  typedef struct packed {
    logic [SW-1:0] code_symbol;
    logic [CW-1:0] code_bits;
    logic [LNW-1:0] code_length;
    logic empty_res;
    logic final_res;
  } code_t;

  logic clk;
  logic rst;

  hcb_in_if #(.COUNT_BITS(CBITS)) in_ch ();
  hcb_out_if out_ch ();

  huffman_code_builder_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Words waiting to be driven, and code words the core still owes us.
  letter_t pending_letters[$];
  code_t expected_codes[$];
  bit stimulus_done;
  int mismatches;
  int idle_cycles;

  // Model state: the leaves loaded so far in the current set, and the tree and heap built from them.
  int unsigned set_size;
  logic [SW-1:0] set_symbols[NLET];
  longint unsigned weight[NNODE];
  int unsigned parent[NNODE];
  bit side[NNODE];
  int unsigned heap[NLET];
  int unsigned heap_len;

  // Gap length: mostly zero or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void heap_sift_down(int unsigned at);
    int unsigned cur, best, l, r, t;
    cur = at;
    forever begin
      best = cur;
      l = 2 * cur + 1;
      r = 2 * cur + 2;
      if (l < heap_len && weight[heap[l]] < weight[heap[best]]) best = l;
      if (r < heap_len && weight[heap[r]] < weight[heap[best]]) best = r;
      if (best == cur) return;
      t = heap[best];
      heap[best] = heap[cur];
      heap[cur] = t;
      cur = best;
    end
  endfunction

  function automatic int unsigned heap_pop();
    int unsigned top;
    top = heap[0];
    heap[0] = heap[heap_len - 1];
    heap_len--;
    heap_sift_down(0);
    return top;
  endfunction

  function automatic void heap_push(int unsigned node);
    int unsigned i;
    i = heap_len;
    heap_len++;
    while (i != 0 && weight[node] < weight[heap[(i - 1) / 2]]) begin
      heap[i] = heap[(i - 1) / 2];
      i = (i - 1) / 2;
    end
    heap[i] = node;
  endfunction

  // Takes one accepted letter word and queues the code words it causes.
  function automatic void predict_codes(letter_t w);
    int unsigned n, nxt, a, b, root, node, len;
    logic [CW-1:0] bits;
    code_t c;
    if (w.count != 0 && set_size < NLET) begin
      set_symbols[set_size] = w.symbol;
      weight[set_size] = 64'(w.count);
      set_size++;
    end
    if (!w.last) return;
    n = set_size;
    set_size = 0;
    if (n == 0) begin
      c = '0;
      c.empty_res = 1'b1;
      c.final_res = 1'b1;
      expected_codes.push_back(c);
      return;
    end
    heap_len = n;
    for (int i = 0; i < n; i++) heap[i] = i;
    if (n >= 2)
      for (int i = (n - 2) / 2; i >= 0; i--) heap_sift_down(i);
    nxt = n;
    while (heap_len > 1 && nxt < NNODE) begin
      a = heap_pop();
      b = heap_pop();
      weight[nxt] = weight[a] + weight[b];
      parent[a] = nxt;
      side[a] = 1'b0;
      parent[b] = nxt;
      side[b] = 1'b1;
      heap_push(nxt);
      nxt++;
    end
    root = heap_pop();
    for (int k = 0; k < n; k++) begin
      bits = '0;
      len = 0;
      node = k;
      // Walk up from the leaf; the leaf-side branch lands in bit 0.
      while (node != root && len < MAXLEN) begin
        bits[len] = side[node];
        len++;
        node = parent[node];
      end
      c.code_symbol = set_symbols[k];
      c.code_bits = bits;
      c.code_length = LNW'(len);
      c.empty_res = 1'b0;
      c.final_res = (k + 1 == n);
      expected_codes.push_back(c);
    end
  endfunction

  function automatic letter_t make_letter(int sym, int unsigned cnt, bit lst);
    letter_t w;
    w.symbol = SW'(sym);
    w.count = CBITS'(cnt);
    w.last = lst;
    return w;
  endfunction

  // Random count: a mix of zero, tiny, power-of-two and full-range values so that
  // ties and deep trees both show up.
  function automatic int unsigned rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 4) return $urandom_range(1, 4);
    if (r < 6) return 1 << $urandom_range(0, 23);
    return $urandom_range(1, (1 << CBITS) - 1);
  endfunction

  // Stimulus. Directed sets cover the empty set, a lone letter, ties,
  // duplicate symbols, symbols above z, a zero-count closing word, a full
  // alphabet with overflow, and Fibonacci counts that give the deepest tree.
  initial begin
    int unsigned fa, fb, ft;
    int total, sz;
    stimulus_done = 1'b0;
    pending_letters.push_back(make_letter(0, 0, 1'b1));
    pending_letters.push_back(make_letter(25, 24'hFFFFFF, 1'b1));
    pending_letters.push_back(make_letter(1, 5, 1'b0));
    pending_letters.push_back(make_letter(1, 5, 1'b0));
    pending_letters.push_back(make_letter(31, 5, 1'b0));
    pending_letters.push_back(make_letter(2, 0, 1'b1));
    pending_letters.push_back(make_letter(31, 24'hFFFFFF, 1'b0));
    pending_letters.push_back(make_letter(0, 24'hFFFFFF, 1'b1));
    pending_letters.push_back(make_letter(16, 1, 1'b0));
    pending_letters.push_back(make_letter(8, 0, 1'b0));
    pending_letters.push_back(make_letter(0, 24'h800000, 1'b1));
    // Full alphabet plus overflow entries that must be dropped.
    for (int i = 0; i < 28; i++)
      pending_letters.push_back(make_letter(i % 32, i + 1, i == 27));
    // Deepest possible tree: Fibonacci weights.
    fa = 1;
    fb = 1;
    for (int i = 0; i < 26; i++) begin
      pending_letters.push_back(make_letter(25 - i, fa, i == 25));
      ft = fa + fb;
      fa = fb;
      fb = ft;
    end
    total = 0;
    while (total < 295) begin
      // Mostly small sets, now and then a large one that may fill the alphabet.
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
      for (int i = 0; i < sz; i++)
        pending_letters.push_back(make_letter($urandom_range(0, 31), rand_count(),
                                              i == sz - 1));
      total += sz;
    end
    stimulus_done = 1'b1;
  end

  // Driver: inputs change on the falling edge only.
  int drive_gap;
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.symbol = '0;
    in_ch.count = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    drive_gap = 0;
    set_size = 0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Set on the rising edge when the driven word was taken.
  bit in_taken;
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready)
      predict_codes(letter_t'({in_ch.symbol, in_ch.count, in_ch.last}));
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken || !in_ch.valid) begin
        if (in_taken) drive_gap = gap_len();
        if (drive_gap > 0 || pending_letters.size() == 0) begin
          if (drive_gap > 0) drive_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          letter_t w;
          w = pending_letters.pop_front();
          in_ch.symbol <= w.symbol;
          in_ch.count <= w.count;
          in_ch.last <= w.last;
          in_ch.valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: random stalls on ready, checking on the rising edge.
  int stall_left;
  initial stall_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        out_ch.ready <= (stall_left == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    code_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.code_symbol = out_ch.code_symbol;
      got.code_bits = out_ch.code_bits;
      got.code_length = out_ch.code_length;
      got.empty_res = out_ch.empty_res;
      got.final_res = out_ch.final_res;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected code word %p", got);
      end else begin
        want = expected_codes.pop_front();
        if (got.code_symbol !== want.code_symbol || got.code_bits !== want.code_bits ||
            got.code_length !== want.code_length || got.empty_res !== want.empty_res ||
            got.final_res !== want.final_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("code word mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("huffman_code_builder_core verification failed");
        $finish;
      end
      if (stimulus_done && pending_letters.size() == 0 && !in_ch.valid &&
          expected_codes.size() == 0) begin
        // Let any stray trailing word show up before the verdict.
        repeat (500) @(posedge clk);
        if (mismatches == 0 && expected_codes.size() == 0)
          $display("huffman_code_builder_core verification clean");
        else
          $display("huffman_code_builder_core verification failed");
        $finish;
      end
    end
  end
endmodule

// ----- files.f -----
rtl/core/hcb_pkg.sv
rtl/core/hcb_if.sv
rtl/core/huffman_code_builder_core.sv
sim/tb_huffman_code_builder_core.sv
